// ----- src/url_percent_decoder_macros.svh -----
// assertion macros for the url percent decoder
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define UPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upd assertion failed");
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upd assertion failed");
`else
`define UPD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/upd_pkg.sv -----
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam int UPD_FIFO_DEPTH = 4;
    localparam int UPD_PTR_W      = $clog2(UPD_FIFO_DEPTH);
    localparam int UPD_CNT_W      = $clog2(UPD_FIFO_DEPTH + 1);
    localparam int UPD_MAX_RUN    = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } upd_phase_t;

    // bytes produced by one input item, index 0 first
    typedef struct packed {
        logic [1:0]                      count;
        logic [UPD_MAX_RUN-1:0][7:0]     bytes;
        logic                            stream_end;
    } upd_run_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } upd_entry_t;

    // upper-case hex digit value, bit 4 set when not a digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic code_listed(input logic [7:0] v);
        return (v >= 8'h20 && v <= 8'h2C) || (v == 8'h2F) ||
               (v >= 8'h3A && v <= 8'h3F) || (v == 8'h40) ||
               (v == 8'h5B) || (v == 8'h5D) || (v == 8'h5E) ||
               (v == 8'h60) || (v >= 8'h7B && v <= 8'h7E);
    endfunction

endpackage

// ----- src/upd_decode.sv -----
`include "url_percent_decoder_macros.svh"

module upd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte,
    input  logic              s_last,
    input  logic              room,
    output logic              push,
    output upd_pkg::upd_run_t run
);
    import upd_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    upd_phase_t phase_reg, phase_next;
    logic [7:0] first_digit_reg, first_digit_next;
    upd_run_t   run_c;
    logic       consume;

    assign consume = in_vld_reg && room;
    assign s_ready = !in_vld_reg || consume;
    assign push    = consume;
    assign run     = run_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            phase_reg       <= PH_IDLE;
            first_digit_reg <= 8'h00;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (consume) begin
                phase_reg       <= phase_next;
                first_digit_reg <= first_digit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte;
            in_last_reg <= s_last;
        end
    end

    always_comb begin
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] val;
        hi               = hex_val(first_digit_reg);
        lo               = hex_val(in_byte_reg);
        val              = {hi[3:0], lo[3:0]};
        run_c            = '0;
        phase_next       = phase_reg;
        first_digit_next = first_digit_reg;
        unique case (phase_reg)
            PH_PCT: begin
                if (in_last_reg) begin
                    run_c.count    = 2'd2;
                    run_c.bytes[0] = PCT_CHAR;
                    run_c.bytes[1] = in_byte_reg;
                end else begin
                    first_digit_next = in_byte_reg;
                    phase_next       = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                if (!hi[4] && !lo[4] && code_listed(val)) begin
                    run_c.count    = 2'd1;
                    run_c.bytes[0] = val;
                end else begin
                    run_c.count    = 2'd3;
                    run_c.bytes[0] = PCT_CHAR;
                    run_c.bytes[1] = first_digit_reg;
                    run_c.bytes[2] = in_byte_reg;
                end
                phase_next       = PH_IDLE;
                first_digit_next = 8'h00;
            end
            default: begin
                if (in_byte_reg == PCT_CHAR && !in_last_reg) begin
                    phase_next = PH_PCT;
                end else begin
                    run_c.count    = 2'd1;
                    run_c.bytes[0] = in_byte_reg;
                    phase_next     = PH_IDLE;
                end
            end
        endcase
        if (in_last_reg) begin
            phase_next       = PH_IDLE;
            first_digit_next = 8'h00;
        end
        run_c.stream_end = in_last_reg;
    end

    `UPD_ASSERT_NEXT(a_last_clears, aclk, aresetn, consume && in_last_reg,
        phase_reg == PH_IDLE && first_digit_reg == 8'h00)
    `UPD_ASSERT_IMPLY(a_pct_holds, aclk, aresetn,
        consume && phase_reg == PH_PCT && !in_last_reg, run_c.count == 2'd0)

endmodule

// ----- src/upd_fifo.sv -----
`include "url_percent_decoder_macros.svh"

module upd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  upd_pkg::upd_run_t run,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_byte,
    output logic              m_run_end,
    output logic              m_stream_end
);
    import upd_pkg::*;

    typedef logic [UPD_PTR_W-1:0] ptr_t;
    typedef logic [UPD_CNT_W-1:0] cnt_t;

    upd_entry_t mem_reg [UPD_FIFO_DEPTH];
    upd_entry_t mem_next [UPD_FIFO_DEPTH];
    ptr_t       wr_ptr_reg, wr_ptr_next;
    ptr_t       rd_ptr_reg, rd_ptr_next;
    cnt_t       cnt_reg, cnt_next;
    logic [1:0] push_cnt;
    logic       pop;

    assign room         = cnt_reg <= cnt_t'(UPD_FIFO_DEPTH - UPD_MAX_RUN);
    assign push_cnt     = push ? run.count : 2'd0;
    assign m_valid      = cnt_reg != '0;
    assign pop          = m_valid && m_ready;
    assign m_byte       = mem_reg[rd_ptr_reg].data;
    assign m_run_end    = mem_reg[rd_ptr_reg].run_end;
    assign m_stream_end = mem_reg[rd_ptr_reg].stream_end;

    always_comb begin
        ptr_t       idx;
        logic       is_end;
        upd_entry_t ent;
        mem_next = mem_reg;
        for (int k = 0; k < UPD_MAX_RUN; k++) begin
            idx            = wr_ptr_reg + ptr_t'(k);
            is_end         = 2'(k) == 2'(run.count - 2'd1);
            ent.data       = run.bytes[k];
            ent.run_end    = is_end;
            ent.stream_end = is_end && run.stream_end;
            if (2'(k) < push_cnt) begin
                mem_next[idx] = ent;
            end
        end
        wr_ptr_next = wr_ptr_reg + ptr_t'(push_cnt);
        rd_ptr_next = rd_ptr_reg + ptr_t'(pop);
        cnt_next    = cnt_reg + cnt_t'(push_cnt) - cnt_t'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mem_reg <= mem_next;
    end

    `UPD_ASSERT_IMPLY(a_cnt_bound, aclk, aresetn, 1'b1,
        cnt_reg <= cnt_t'(UPD_FIFO_DEPTH))
    `UPD_ASSERT_IMPLY(a_push_room, aclk, aresetn, push_cnt != 2'd0,
        cnt_reg <= cnt_t'(UPD_FIFO_DEPTH - UPD_MAX_RUN))
    `UPD_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && push_cnt == 2'd0,
        cnt_reg == $past(cnt_reg) - cnt_t'(1))

endmodule

// ----- src/url_percent_decoder.sv -----
// url percent decoder
// s_ channel: one encoded byte per item, s_last on the final byte of a string.
// m_ channel: decoded bytes; m_run_end on the last byte caused by one input
// item, m_stream_end on the final decoded byte of the string.
// a '%' followed by a listed upper-case code gives one decoded byte, any other
// triple gives its three bytes raw; bytes held at the end of a string go out raw.
// an accepted byte is held in the input register until the queue has room.
// throughput: one input item per cycle while the four-entry output queue has
// room for a full three-byte run; output drains one byte per cycle while
// m_ready is high, so the sustained output rate is at most one byte per cycle.
// when the receiver stalls the queue fills and s_ready drops; nothing is lost.
// reset (aresetn low, synchronous) empties the queue and the input register and
// drops any pending escape.
module url_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_run_end,
    output logic       m_stream_end
);
    import upd_pkg::*;

    upd_run_t run;
    logic     push;
    logic     room;

    upd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_byte  (s_byte),
        .s_last  (s_last),
        .room    (room),
        .push    (push),
        .run     (run)
    );

    upd_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .run          (run),
        .room         (room),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte       (m_byte),
        .m_run_end    (m_run_end),
        .m_stream_end (m_stream_end)
    );

endmodule
